// File: hdl/dafs_pkg.sv
// Shared constants, codes and types of the delayed alpha fade sequencer.
package dafs_pkg;

  localparam int unsigned TIME_BITS    = 24;
  localparam int unsigned ALPHA_BITS   = 16;
  localparam int unsigned ELAPSED_BITS = TIME_BITS + 1;
  localparam int unsigned PROD_BITS    = ALPHA_BITS + TIME_BITS;
  localparam int unsigned CNT_BITS     = $clog2(ALPHA_BITS);
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [ALPHA_BITS-1:0]   AlphaMax   = {ALPHA_BITS{1'b1}};
  localparam logic [ELAPSED_BITS-1:0] ElapsedMax = {ELAPSED_BITS{1'b1}};

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_FADE_IN   = 3'd1,
    MODE_FADE_OUT  = 3'd2,
    MODE_RESTART   = 3'd3,
    MODE_SET_ALPHA = 3'd4
  } dafs_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IN_DELAY   = 2'd0,
    REG_IN_LENGTH  = 2'd1,
    REG_OUT_DELAY  = 2'd2,
    REG_OUT_LENGTH = 2'd3
  } dafs_reg_e;

  // One ramp evaluation: floor(target * p / len), with p = len - pos when falling.
  typedef struct packed {
    logic                  start;
    logic                  falling;
    logic [ALPHA_BITS-1:0] target;
    logic [TIME_BITS-1:0]  pos;
    logic [TIME_BITS-1:0]  len;
  } dafs_ramp_req_t;

endpackage

// File: hdl/dafs_ramp.sv
// Shared ramp unit: one multiply followed by a restoring divide, one quotient bit a cycle.
module dafs_ramp import dafs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dafs_ramp_req_t        req_i,
  output logic                  done_o,
  output logic [ALPHA_BITS-1:0] quot_o
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_PREP = 4'b0010,
    R_MUL  = 4'b0100,
    R_DIV  = 4'b1000
  } ramp_state_e;

  ramp_state_e           state_q, state_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  falling_q;
  logic [ALPHA_BITS-1:0] target_q;
  logic [TIME_BITS-1:0]  pos_q;
  logic [TIME_BITS-1:0]  len_q;
  logic [TIME_BITS-1:0]  num_q;
  logic [TIME_BITS-1:0]  rem_q;
  logic [ALPHA_BITS-1:0] low_q;

  logic [PROD_BITS-1:0]  prod;
  logic [TIME_BITS:0]    trial;
  logic                  fits;

  assign prod  = PROD_BITS'(target_q) * PROD_BITS'(num_q);
  assign trial = {rem_q, low_q[ALPHA_BITS-1]};
  assign fits  = trial >= {1'b0, len_q};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          state_d = R_PREP;
        end
      end
      R_PREP: state_d = R_MUL;
      R_MUL: begin
        cnt_d   = CNT_BITS'(ALPHA_BITS - 1);
        state_d = R_DIV;
      end
      R_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = R_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == R_IDLE && req_i.start) begin
      falling_q <= req_i.falling;
      target_q  <= req_i.target;
      pos_q     <= req_i.pos;
      len_q     <= req_i.len;
    end
    if (state_q == R_PREP) begin
      num_q <= falling_q ? (len_q - pos_q) : pos_q;
    end
    // The upper product bits are below len because pos never exceeds len.
    if (state_q == R_MUL) begin
      rem_q <= prod[PROD_BITS-1:ALPHA_BITS];
      low_q <= prod[ALPHA_BITS-1:0];
    end
    if (state_q == R_DIV) begin
      rem_q <= fits ? TIME_BITS'(trial - {1'b0, len_q}) : trial[TIME_BITS-1:0];
      low_q <= {low_q[ALPHA_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

`ifndef SYNTHESIS
  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == R_DIV) |-> (rem_q < len_q))
    else $error("ramp remainder not below length");
  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == R_DIV))
    else $error("ramp done without a divide step");
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == R_IDLE))
    else $error("ramp started while busy");
`endif

endmodule

// File: hdl/delayed_alpha_fade_sequencer.sv
// Top level of the delayed alpha fade sequencer: command decode, phase sequencer, output register.
//
// Use: commands enter on the in channel (mode_i, delta_i, alpha_value_i) with
// in_valid_i / in_ready_o; each accepted command gives exactly one result
// transfer on the out channel (alpha_o, visible_o, in_active_o, out_active_o,
// alpha_changed_o) with out_valid_o / out_ready_i. Alpha is unsigned Q0.16.
// Timing registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must write them only while no command is in flight, which the block itself
// does not enforce. A write takes effect at once. A non-tick command passes only
// the result state before the sequencer is idle again. A tick runs the fade-in
// phase, then the fade-out phase. A stopped phase passes only add, a phase still
// in its delay add and check, a phase with zero length add, check and finish, and
// a ramping phase also waits on the shared ramp unit (prepare, multiply, 16
// restoring-divide steps, collect) between check and finish.
// One command is processed at a time: in_ready_o is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next command can be taken while that result still waits; if the receiver
// stalls, the sequencer holds the following result until the register frees.
// Reset: alpha and target are opaque, the output is shown, both phases are
// stopped, elapsed counts and timing registers are zero, no result is pending.
module delayed_alpha_fade_sequencer import dafs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [TIME_BITS-1:0]    cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              mode_i,
  input  logic [15:0]             delta_i,
  input  logic [ALPHA_BITS-1:0]   alpha_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ALPHA_BITS-1:0]   alpha_o,
  output logic                    visible_o,
  output logic                    in_active_o,
  output logic                    out_active_o,
  output logic                    alpha_changed_o
);

  // Sequencer states. Per phase a tick walks ADD, then CHK if running, then DIV if
  // ramping and END past the delay; RESP waits for the output register, then hands over the result.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_END  = 6'b010000,
    S_RESP = 6'b100000
  } seq_state_e;

  seq_state_e state_q, state_d;

  // Timing registers.
  logic [TIME_BITS-1:0] in_delay_q, in_length_q, out_delay_q, out_length_q;

  // Envelope state.
  logic [ELAPSED_BITS-1:0] in_el_q, in_el_d, out_el_q, out_el_d;
  logic                    in_running_q, in_running_d;
  logic                    out_running_q, out_running_d;
  logic                    out_pending_q, out_pending_d;
  logic                    shown_q, shown_d;
  logic [ALPHA_BITS-1:0]   cur_alpha_q, cur_alpha_d;
  logic [ALPHA_BITS-1:0]   tgt_alpha_q, tgt_alpha_d;

  // Per-command working registers: phase 0 is fade-in, phase 1 is fade-out.
  logic        phase_q, phase_d;
  logic        changed_q, changed_d;
  logic        fin_q, fin_d;
  logic [15:0] delta_q;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [ALPHA_BITS-1:0] out_alpha_q;
  logic                  out_visible_q, out_in_q, out_out_q, out_changed_q;
  logic                  load_out;

  // Ramp unit.
  dafs_ramp_req_t        ramp_req;
  logic                  ramp_done;
  logic [ALPHA_BITS-1:0] ramp_quot;

  // Values of the phase selected by phase_q.
  logic [ELAPSED_BITS-1:0] sel_el;
  logic [TIME_BITS-1:0]    sel_delay, sel_len;
  logic                    sel_running;
  logic [ELAPSED_BITS:0]   sat_sum;
  logic [ELAPSED_BITS-1:0] sat_el;
  logic                    past_delay;
  logic [ELAPSED_BITS-1:0] since_delay;
  logic [TIME_BITS-1:0]    ramp_pos;
  logic [ELAPSED_BITS-1:0] phase_end;
  logic                    has_in, has_out;
  logic                    in_xfer;

  assign sel_el      = phase_q ? out_el_q : in_el_q;
  assign sel_delay   = phase_q ? out_delay_q : in_delay_q;
  assign sel_len     = phase_q ? out_length_q : in_length_q;
  assign sel_running = phase_q ? out_running_q : in_running_q;

  assign sat_sum     = {1'b0, sel_el} + (ELAPSED_BITS + 1)'(delta_q);
  assign sat_el      = sat_sum[ELAPSED_BITS] ? ElapsedMax : sat_sum[ELAPSED_BITS-1:0];

  assign past_delay  = sel_el >= {1'b0, sel_delay};
  assign since_delay = sel_el - {1'b0, sel_delay};
  assign ramp_pos    = (since_delay > {1'b0, sel_len}) ? sel_len
                                                       : since_delay[TIME_BITS-1:0];
  assign phase_end   = {1'b0, sel_delay} + {1'b0, sel_len};

  assign has_in  = (in_delay_q != '0) || (in_length_q != '0);
  assign has_out = (out_delay_q != '0) || (out_length_q != '0);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    in_el_d       = in_el_q;
    out_el_d      = out_el_q;
    in_running_d  = in_running_q;
    out_running_d = out_running_q;
    out_pending_d = out_pending_q;
    shown_d       = shown_q;
    cur_alpha_d   = cur_alpha_q;
    tgt_alpha_d   = tgt_alpha_q;
    phase_d       = phase_q;
    changed_d     = changed_q;
    fin_d         = fin_q;
    ramp_req      = '0;
    ramp_req.falling = phase_q;
    ramp_req.target  = tgt_alpha_q;
    ramp_req.pos     = ramp_pos;
    ramp_req.len     = sel_len;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          phase_d   = 1'b0;
          changed_d = 1'b0;
          state_d   = S_RESP;
          case (mode_i)
            MODE_TICK: begin
              state_d = S_ADD;
            end
            MODE_FADE_IN: begin
              out_running_d = 1'b0;
              in_el_d       = '0;
              in_running_d  = 1'b1;
              if (tgt_alpha_q == '0) begin
                tgt_alpha_d = (cur_alpha_q != '0) ? cur_alpha_q : AlphaMax;
              end
              cur_alpha_d = '0;
              shown_d     = 1'b1;
              changed_d   = 1'b1;
            end
            MODE_FADE_OUT: begin
              in_running_d  = 1'b0;
              out_el_d      = '0;
              out_running_d = 1'b1;
              out_pending_d = 1'b0;
              tgt_alpha_d   = cur_alpha_q;
              shown_d       = 1'b1;
            end
            MODE_RESTART: begin
              shown_d = 1'b1;
              if (has_in) begin
                out_pending_d = has_out;
                out_running_d = 1'b0;
                in_el_d       = '0;
                in_running_d  = 1'b1;
                if (tgt_alpha_q == '0) begin
                  tgt_alpha_d = (cur_alpha_q != '0) ? cur_alpha_q : AlphaMax;
                end
                cur_alpha_d = '0;
                changed_d   = 1'b1;
              end else if (has_out) begin
                in_running_d  = 1'b0;
                out_el_d      = '0;
                out_running_d = 1'b1;
                out_pending_d = 1'b0;
                tgt_alpha_d   = cur_alpha_q;
              end else begin
                in_running_d  = 1'b0;
                out_running_d = 1'b0;
                out_pending_d = 1'b0;
                cur_alpha_d   = tgt_alpha_q;
                changed_d     = 1'b1;
              end
            end
            MODE_SET_ALPHA: begin
              cur_alpha_d = alpha_value_i;
              if (!in_running_q && !out_running_q) begin
                tgt_alpha_d = alpha_value_i;
              end
              changed_d = 1'b1;
            end
            default: begin
              // Unused modes only report the current state.
            end
          endcase
        end
      end

      S_ADD: begin
        if (sel_running) begin
          if (phase_q) begin
            out_el_d = sat_el;
          end else begin
            in_el_d = sat_el;
          end
          state_d = S_CHK;
        end else if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          state_d = S_RESP;
        end
      end

      S_CHK: begin
        if (past_delay) begin
          changed_d = 1'b1;
          fin_d     = sel_el >= phase_end;
          if (sel_len != '0) begin
            ramp_req.start = 1'b1;
            state_d        = S_DIV;
          end else begin
            cur_alpha_d = phase_q ? '0 : tgt_alpha_q;
            state_d     = S_END;
          end
        end else if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_ADD;
        end else begin
          state_d = S_RESP;
        end
      end

      S_DIV: begin
        if (ramp_done) begin
          cur_alpha_d = ramp_quot;
          state_d     = S_END;
        end
      end

      S_END: begin
        if (fin_q) begin
          if (!phase_q) begin
            in_running_d = 1'b0;
            // A pending fade-out starts here and is advanced by this same tick.
            if (out_pending_q && has_out) begin
              out_el_d      = '0;
              out_running_d = 1'b1;
              tgt_alpha_d   = cur_alpha_q;
              shown_d       = 1'b1;
            end
            out_pending_d = 1'b0;
          end else begin
            out_running_d = 1'b0;
            shown_d       = 1'b0;
          end
        end
        if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_ADD;
        end else begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      in_delay_q    <= '0;
      in_length_q   <= '0;
      out_delay_q   <= '0;
      out_length_q  <= '0;
      in_el_q       <= '0;
      out_el_q      <= '0;
      in_running_q  <= 1'b0;
      out_running_q <= 1'b0;
      out_pending_q <= 1'b0;
      shown_q       <= 1'b1;
      cur_alpha_q   <= AlphaMax;
      tgt_alpha_q   <= AlphaMax;
      phase_q       <= 1'b0;
      changed_q     <= 1'b0;
      fin_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      in_el_q       <= in_el_d;
      out_el_q      <= out_el_d;
      in_running_q  <= in_running_d;
      out_running_q <= out_running_d;
      out_pending_q <= out_pending_d;
      shown_q       <= shown_d;
      cur_alpha_q   <= cur_alpha_d;
      tgt_alpha_q   <= tgt_alpha_d;
      phase_q       <= phase_d;
      changed_q     <= changed_d;
      fin_q         <= fin_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IN_DELAY:   in_delay_q   <= cfg_wdata_i;
          REG_IN_LENGTH:  in_length_q  <= cfg_wdata_i;
          REG_OUT_DELAY:  out_delay_q  <= cfg_wdata_i;
          REG_OUT_LENGTH: out_length_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: the tick delta and the result fields.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      delta_q <= delta_i;
    end
    if (load_out) begin
      out_alpha_q   <= cur_alpha_q;
      out_visible_q <= shown_q;
      out_in_q      <= in_running_q;
      out_out_q     <= out_running_q;
      out_changed_q <= changed_q;
    end
  end

  dafs_ramp u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ramp_req),
    .done_o (ramp_done),
    .quot_o (ramp_quot)
  );

  assign out_valid_o     = out_valid_q;
  assign alpha_o         = out_alpha_q;
  assign visible_o       = out_visible_q;
  assign in_active_o     = out_in_q;
  assign out_active_o    = out_out_q;
  assign alpha_changed_o = out_changed_q;

`ifndef SYNTHESIS
  a_phases_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_running_q && out_running_q))
    else $error("fade-in and fade-out running together");
  a_pending_needs_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pending_q |-> in_running_q)
    else $error("fade-out pending without a running fade-in");
  a_ramp_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_done |-> (state_q == S_DIV))
    else $error("ramp result arrived outside the divide wait");
`endif

endmodule
